### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/lpsn_pkg.sv
// ---------------------------------------------------------------------------
// lpsn_pkg
// shared types and constants of the scan packet nearest-sample block
// ---------------------------------------------------------------------------
`default_nettype none

package lpsn_pkg;

  localparam int ByteW   = 8;
  localparam int DistW   = 16;
  localparam int AngleW  = 15;
  localparam int QualW   = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int OutDataW = 32;

  localparam logic [DistW-1:0]  NoneDist      = 16'd39996;
  localparam logic [DistW-1:0]  MaxRangeRst   = 16'd4000;
  localparam logic [AngleW-1:0] LowEndRst     = 15'd1920;
  localparam logic [AngleW-1:0] HighStartRst  = 15'd21120;

  localparam logic [1:0] SyncA = 2'b01;
  localparam logic [1:0] SyncB = 2'b10;

  typedef enum logic [2:0] {
    POS_B0 = 3'd0,
    POS_B1 = 3'd1,
    POS_B2 = 3'd2,
    POS_B3 = 3'd3,
    POS_B4 = 3'd4
  } pos_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_RANGE  = 2'd0,
    REG_LOW_END    = 2'd1,
    REG_HIGH_START = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              done;
    logic              start;
    logic [QualW-1:0]  quality;
    logic [AngleW-1:0] angle;
    logic [DistW-1:0]  dist_q2;
  } pkt_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [DistW-1:0]  dist_q2;
  } result_t;

endpackage

`default_nettype wire

### sv/lpsn_framer.sv
// ---------------------------------------------------------------------------
// lpsn_framer
// frames raw bytes into five-byte scan packets and decodes the fields
// ---------------------------------------------------------------------------
`default_nettype none

module lpsn_framer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [lpsn_pkg::ByteW-1:0]   rx_byte,
  output lpsn_pkg::pkt_t                    pkt
);

  lpsn_pkg::pos_t            pos_r, pos_nxt;
  logic [lpsn_pkg::ByteW-1:0] b0_r, b1_r, b2_r, b3_r;
  logic                      sync_ok;
  logic                      ld_b0, ld_b1, ld_b2, ld_b3;

  assign sync_ok = (rx_byte[1:0] == lpsn_pkg::SyncA) || (rx_byte[1:0] == lpsn_pkg::SyncB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= lpsn_pkg::POS_B0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

  // packet byte store, no reset
  always_ff @(posedge clk) begin
    if (step && ld_b0) begin
      b0_r <= rx_byte;
    end
    if (step && ld_b1) begin
      b1_r <= rx_byte;
    end
    if (step && ld_b2) begin
      b2_r <= rx_byte;
    end
    if (step && ld_b3) begin
      b3_r <= rx_byte;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    ld_b0   = 1'b0;
    ld_b1   = 1'b0;
    ld_b2   = 1'b0;
    ld_b3   = 1'b0;
    pkt     = '0;
    case (pos_r)
      lpsn_pkg::POS_B0: begin
        ld_b0   = sync_ok;
        pos_nxt = sync_ok ? lpsn_pkg::POS_B1 : lpsn_pkg::POS_B0;
      end
      lpsn_pkg::POS_B1: begin
        if (rx_byte[0]) begin
          ld_b1   = 1'b1;
          pos_nxt = lpsn_pkg::POS_B2;
        end else begin
          // failed check bit, retry as a first byte
          ld_b0   = sync_ok;
          pos_nxt = sync_ok ? lpsn_pkg::POS_B1 : lpsn_pkg::POS_B0;
        end
      end
      lpsn_pkg::POS_B2: begin
        ld_b2   = 1'b1;
        pos_nxt = lpsn_pkg::POS_B3;
      end
      lpsn_pkg::POS_B3: begin
        ld_b3   = 1'b1;
        pos_nxt = lpsn_pkg::POS_B4;
      end
      lpsn_pkg::POS_B4: begin
        pos_nxt     = lpsn_pkg::POS_B0;
        pkt.done    = 1'b1;
        pkt.start   = b0_r[0];
        pkt.quality = b0_r[7:2];
        pkt.angle   = {b2_r, b1_r[7:1]};
        pkt.dist_q2 = {rx_byte, b3_r};
      end
      default: begin
        pos_nxt = lpsn_pkg::POS_B0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/lpsn_tracker.sv
// ---------------------------------------------------------------------------
// lpsn_tracker
// range and sector window, nearest sample per revolution, config registers
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpsn_tracker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  lpsn_pkg::pkt_t         pkt,
  input  lpsn_pkg::cfg_wr_t      cfg,
  output logic                   emit,
  output lpsn_pkg::result_t      res
);

  logic [lpsn_pkg::DistW-1:0]  max_range_r;
  logic [lpsn_pkg::AngleW-1:0] low_end_r;
  logic [lpsn_pkg::AngleW-1:0] high_start_r;
  logic [lpsn_pkg::DistW-1:0]  best_dist_r, best_dist_nxt;
  logic [lpsn_pkg::AngleW-1:0] best_angle_r, best_angle_nxt;
  logic [lpsn_pkg::DistW-1:0]  base_dist;
  logic [lpsn_pkg::AngleW-1:0] base_angle;
  logic                        in_window;
  logic                        take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r  <= lpsn_pkg::MaxRangeRst;
      low_end_r    <= lpsn_pkg::LowEndRst;
      high_start_r <= lpsn_pkg::HighStartRst;
    end else if (cfg.we) begin
      case (cfg.index)
        lpsn_pkg::REG_MAX_RANGE:  max_range_r  <= cfg.data;
        lpsn_pkg::REG_LOW_END:    low_end_r    <= cfg.data[lpsn_pkg::AngleW-1:0];
        lpsn_pkg::REG_HIGH_START: high_start_r <= cfg.data[lpsn_pkg::AngleW-1:0];
        default: ;
      endcase
    end
  end

  assign emit = pkt.done && pkt.start;
  assign res.dist_q2 = best_dist_r;
  assign res.angle   = best_angle_r;

  // start packet restarts tracking before its own sample is weighed
  assign base_dist  = emit ? lpsn_pkg::NoneDist : best_dist_r;
  assign base_angle = emit ? '0 : best_angle_r;

  assign in_window = (pkt.quality != '0) && (pkt.dist_q2 != '0) && (pkt.dist_q2 <= max_range_r)
                  && ((pkt.angle <= low_end_r) || (pkt.angle >= high_start_r));
  assign take = pkt.done && in_window && (pkt.dist_q2 < base_dist);

  always_comb begin
    best_dist_nxt  = base_dist;
    best_angle_nxt = base_angle;
    if (take) begin
      best_dist_nxt  = pkt.dist_q2;
      best_angle_nxt = pkt.angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r  <= lpsn_pkg::NoneDist;
      best_angle_r <= '0;
    end else if (step) begin
      best_dist_r  <= best_dist_nxt;
      best_angle_r <= best_angle_nxt;
    end
  end

  `ASSERT_IMPL(a_best_nonzero, clk, rst_n, 1'b1, best_dist_r != '0)
  `ASSERT_NEXT(a_hold_mid_packet, clk, rst_n, step && !pkt.done, $stable(best_dist_r))
  `ASSERT_NEXT(a_start_restarts, clk, rst_n, step && emit && !take,
               best_dist_r == lpsn_pkg::NoneDist && best_angle_r == '0)

endmodule

`default_nettype wire

### sv/lidar_packet_sector_nearest_top.sv
// ---------------------------------------------------------------------------
// lidar_packet_sector_nearest_top
// scan packet framer with forward-sector nearest-sample report
// ---------------------------------------------------------------------------
// in_*  : one raw link byte per word, in_tdata[7:0]
// out_* : one word per start packet, nearest sample of the revolution that
//         just ended; distance 39996 and angle 0 if no sample qualified
// cfg_* : register writes, index 0 max range, 1 sector low end,
//         2 sector high start; other indexes are ignored; cfg_ready is
//         always high, write only while no bytes are in flight
// a byte is registered on accept and decoded in the next cycle; the byte
// that completes a start packet loads its result word into the output register
// throughput is one byte per cycle while no result is held back, set by the
// single input register and decode stage feeding the output register
// when out_tready is low with a result waiting, bytes keep flowing until a
// further result would be produced, then in_tready drops
// reset (rst_n low, synchronous) empties both registers, restarts framing
// at byte 0, loads register defaults and clears the tracked sample
// ---------------------------------------------------------------------------
`default_nettype none

module lidar_packet_sector_nearest_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lpsn_pkg::ByteW-1:0]        in_tdata,   // [7:0] rx_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lpsn_pkg::OutDataW-1:0]          out_tdata,  // [15:0] nearest_distance_q2,
                                                             // [30:16] nearest_angle_q6
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [lpsn_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [lpsn_pkg::CfgDataW-1:0]     cfg_data
);

  logic                        in_valid_r;
  logic [lpsn_pkg::ByteW-1:0]  in_byte_r;
  logic                        out_valid_r;
  lpsn_pkg::result_t           out_res_r;
  logic                        proceed;
  logic                        emit;
  lpsn_pkg::pkt_t              pkt;
  lpsn_pkg::result_t           res;
  lpsn_pkg::cfg_wr_t           cfg;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign proceed   = in_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proceed) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  lpsn_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proceed),
    .rx_byte (in_byte_r),
    .pkt     (pkt)
  );

  lpsn_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (proceed),
    .pkt   (pkt),
    .cfg   (cfg),
    .emit  (emit),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.angle, out_res_r.dist_q2};

endmodule

`default_nettype wire
